// ===== design/cht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cht_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int KEY_W     = 32;
    localparam int HASH_W    = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 11;

    localparam logic [CNT_W-1:0] MAX_FILL_RST = 11'd717;

    localparam logic [31:0] HC_X   = 32'd73856093;
    localparam logic [31:0] HC_Y   = 32'd19349663;
    localparam logic [31:0] HC_Z   = 32'd83492791;
    localparam logic [31:0] HC_MIX = 32'h85ebca6b;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_NOT_FOUND = 3'd0,
        ST_FOUND     = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        SL_EMPTY = 2'd0,
        SL_USED  = 2'd1,
        SL_TOMB  = 2'd2
    } t_slot_st;

    typedef struct packed {
        logic [KEY_W-1:0]  key_x;
        logic [KEY_W-1:0]  key_y;
        logic [KEY_W-1:0]  key_z;
        logic [HASH_W-1:0] hash;
        logic [VAL_W-1:0]  value;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_Z,
        S_MIX_LO,
        S_MIX_HI,
        S_MOD,
        S_MODQ,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== design/cht_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface cht_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  mode;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic        [31:0] value_in;
    modport source (output valid, mode, key_x, key_y, key_z, value_in, input ready);
    modport sink   (input valid, mode, key_x, key_y, key_z, value_in, output ready);
endinterface

interface cht_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] value_out;
    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface
`default_nettype wire

// ===== design/cht_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/coord_hash_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Hash table on (x, y, z) keys with linear probing and tombstones. One word is
// taken at a time: the shared 32x32 multiplier builds the hash in MUL_X, MUL_Y,
// MUL_Z, MIX_LO and MIX_HI, then each probed slot takes a slot RAM read (READ),
// then a compare (CHECK), and the result is posted from DONE. When SLOTS is not
// a power of two the home slot is reduced on the same multiplier, sixteen hash
// bits at a time, in MOD and MODQ. Lookups and removes on an empty table and
// mode 3 skip the hash and go straight to DONE.
// After reset the slot state RAM is cleared one slot a cycle while the input is
// not ready; max_fill may be written at any time the block is idle.
module coord_hash_table_unit #(
    parameter int SLOTS = cht_pkg::SLOTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    cht_in_if.sink                        i_req,
    cht_out_if.source                     o_rsp,
    input  wire logic                     i_cfg_we,
    input  wire logic [cht_pkg::CNT_W-1:0] i_cfg_wdata
);
    localparam int IDXW = $clog2(SLOTS);
    localparam bit POW2 = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [IDXW:0]   SLOTS_W = (IDXW + 1)'(SLOTS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
    localparam logic [31:0]     SLOTS_32 = 32'(SLOTS);
    // floor(2^32 / SLOTS): quotient estimate is low by at most one
    localparam logic [31:0]     RECIP = 32'((64'd1 << 32) / SLOTS);

    cht_pkg::t_state r_state, n_state;

    logic [31:0]               r_key_x, r_key_y, r_key_z, r_val;
    cht_pkg::t_mode            r_mode;
    logic [63:0]               r_h, r_t;
    logic [31:0]               r_g_hi;
    logic [IDXW:0]             r_rem;
    logic [1:0]                r_bit;
    logic [31:0]               r_q, r_tq;
    logic [IDXW-1:0]           r_idx, r_clr_idx, r_tomb;
    logic [IDXW:0]             r_n;
    logic                      r_have_tomb;
    logic [cht_pkg::CNT_W-1:0] r_count, r_max_fill;
    cht_pkg::t_status          r_res_status;
    logic [31:0]               r_res_value;
    logic                      r_out_valid;
    cht_pkg::t_status          r_out_status;
    logic [31:0]               r_out_value;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p, mix_g, mix_v;
    logic [15:0] rem_dig;
    logic [31:0] rem_t, rem_d;
    logic [IDXW:0] rem_n;

    // slot RAMs
    logic                st_we, pl_we;
    logic [IDXW-1:0]     st_waddr, pl_waddr;
    logic [1:0]          st_wdata, st_rdata;
    cht_pkg::t_slot      pl_wdata, pl_rdata_s;
    logic [cht_pkg::SLOT_W-1:0] pl_rdata;

    // probe decisions
    cht_pkg::t_slot_st c_st;
    logic              c_match, c_last, c_end, c_tomb_seen, c_inc, c_dec;
    logic [IDXW-1:0]   c_tomb_idx;
    cht_pkg::t_status  c_status;
    logic [31:0]       c_value;

    logic in_acc, out_free;

    assign in_acc   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready     = (r_state == cht_pkg::S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.value_out = r_out_value;

    assign mix_g = r_h ^ (r_h >> 16);

    // remainder digit, most significant first
    always_comb begin
        case (r_bit)
            2'd3:    rem_dig = r_h[63:48];
            2'd2:    rem_dig = r_h[47:32];
            2'd1:    rem_dig = r_h[31:16];
            default: rem_dig = r_h[15:0];
        endcase
    end

    assign rem_t = {16'(r_rem), rem_dig};

    always_comb begin
        mul_a = r_key_x;
        mul_b = cht_pkg::HC_X;
        case (r_state)
            cht_pkg::S_MUL_Y: begin
                mul_a = r_key_y;
                mul_b = cht_pkg::HC_Y;
            end
            cht_pkg::S_MUL_Z: begin
                mul_a = r_key_z;
                mul_b = cht_pkg::HC_Z;
            end
            cht_pkg::S_MIX_LO: begin
                mul_a = mix_g[31:0];
                mul_b = cht_pkg::HC_MIX;
            end
            cht_pkg::S_MIX_HI: begin
                mul_a = r_g_hi;
                mul_b = cht_pkg::HC_MIX;
            end
            cht_pkg::S_MOD: begin
                mul_a = rem_t;
                mul_b = RECIP;
            end
            cht_pkg::S_MODQ: begin
                mul_a = r_q;
                mul_b = SLOTS_32;
            end
            default: begin
                mul_a = r_key_x;
                mul_b = cht_pkg::HC_X;
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    assign mix_v = r_t + {mul_p[31:0], 32'd0};
    assign rem_d = r_tq - mul_p[31:0];
    assign rem_n = (rem_d >= SLOTS_32) ? (IDXW + 1)'(rem_d - SLOTS_32)
                                       : (IDXW + 1)'(rem_d);

    cht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (r_idx),
        .o_rdata (st_rdata)
    );

    cht_ram #(.WIDTH(cht_pkg::SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_raddr (r_idx),
        .o_rdata (pl_rdata)
    );

    assign pl_rdata_s = cht_pkg::t_slot'(pl_rdata);

    // slot compare and decision in the check cycle
    always_comb begin
        c_st        = cht_pkg::t_slot_st'(st_rdata);
        c_match     = (c_st == cht_pkg::SL_USED) && (pl_rdata_s.hash == r_h)
                      && (pl_rdata_s.key_x == r_key_x) && (pl_rdata_s.key_y == r_key_y)
                      && (pl_rdata_s.key_z == r_key_z);
        c_last      = (r_n == SLOTS_W - 1'b1);
        c_end       = (c_st == cht_pkg::SL_EMPTY) || c_match || c_last;
        c_tomb_seen = r_have_tomb || (c_st == cht_pkg::SL_TOMB);
        c_tomb_idx  = r_have_tomb ? r_tomb : r_idx;
        c_status    = cht_pkg::ST_NOT_FOUND;
        c_value     = '0;
        c_inc       = 1'b0;
        c_dec       = 1'b0;
        st_we       = 1'b0;
        st_waddr    = r_idx;
        st_wdata    = cht_pkg::SL_EMPTY;
        pl_we       = 1'b0;
        pl_waddr    = r_idx;
        pl_wdata    = '{key_x: r_key_x, key_y: r_key_y, key_z: r_key_z,
                        hash: r_h, value: r_val};
        if (r_state == cht_pkg::S_CLEAR) begin
            st_we    = 1'b1;
            st_waddr = r_clr_idx;
        end else if (r_state == cht_pkg::S_CHECK && c_end) begin
            if (c_match) begin
                case (r_mode)
                    cht_pkg::MODE_LOOKUP: begin
                        c_status = cht_pkg::ST_FOUND;
                        c_value  = pl_rdata_s.value;
                    end
                    cht_pkg::MODE_INSERT: begin
                        c_status = cht_pkg::ST_FOUND;
                        pl_we    = 1'b1;
                    end
                    cht_pkg::MODE_REMOVE: begin
                        c_status = cht_pkg::ST_REMOVED;
                        st_we    = 1'b1;
                        st_wdata = cht_pkg::SL_TOMB;
                        c_dec    = 1'b1;
                    end
                    default: c_status = cht_pkg::ST_NOT_FOUND;
                endcase
            end else if (r_mode == cht_pkg::MODE_INSERT) begin
                if (r_count >= r_max_fill
                    || (!c_tomb_seen && c_st != cht_pkg::SL_EMPTY)) begin
                    c_status = cht_pkg::ST_FULL;
                end else begin
                    c_status = cht_pkg::ST_INSERTED;
                    c_inc    = 1'b1;
                    st_we    = 1'b1;
                    pl_we    = 1'b1;
                    st_wdata = cht_pkg::SL_USED;
                    st_waddr = c_tomb_seen ? c_tomb_idx : r_idx;
                    pl_waddr = c_tomb_seen ? c_tomb_idx : r_idx;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cht_pkg::S_CLEAR:  if (r_clr_idx == LAST_IDX) n_state = cht_pkg::S_IDLE;
            cht_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_req.mode == cht_pkg::MODE_NOP
                        || (i_req.mode != cht_pkg::MODE_INSERT && r_count == '0)) begin
                        n_state = cht_pkg::S_DONE;
                    end else begin
                        n_state = cht_pkg::S_MUL_X;
                    end
                end
            end
            cht_pkg::S_MUL_X:  n_state = cht_pkg::S_MUL_Y;
            cht_pkg::S_MUL_Y:  n_state = cht_pkg::S_MUL_Z;
            cht_pkg::S_MUL_Z:  n_state = cht_pkg::S_MIX_LO;
            cht_pkg::S_MIX_LO: n_state = cht_pkg::S_MIX_HI;
            cht_pkg::S_MIX_HI: n_state = POW2 ? cht_pkg::S_READ : cht_pkg::S_MOD;
            cht_pkg::S_MOD:    n_state = cht_pkg::S_MODQ;
            cht_pkg::S_MODQ:   n_state = (r_bit == '0) ? cht_pkg::S_READ : cht_pkg::S_MOD;
            cht_pkg::S_READ:   n_state = cht_pkg::S_CHECK;
            cht_pkg::S_CHECK:  n_state = c_end ? cht_pkg::S_DONE : cht_pkg::S_READ;
            cht_pkg::S_DONE:   if (out_free) n_state = cht_pkg::S_IDLE;
            default:           n_state = cht_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cht_pkg::S_CLEAR;
            r_clr_idx    <= '0;
            r_count      <= '0;
            r_max_fill   <= cht_pkg::MAX_FILL_RST;
            r_out_valid  <= 1'b0;
            r_have_tomb  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_fill <= i_cfg_wdata;
            end
            if (r_state == cht_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (c_inc) r_count <= r_count + 1'b1;
            if (c_dec) r_count <= r_count - 1'b1;
            if (r_state == cht_pkg::S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_have_tomb <= 1'b0;
            end else if (r_state == cht_pkg::S_CHECK && c_st == cht_pkg::SL_TOMB) begin
                r_have_tomb <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            cht_pkg::S_IDLE: begin
                r_key_x      <= i_req.key_x;
                r_key_y      <= i_req.key_y;
                r_key_z      <= i_req.key_z;
                r_val        <= i_req.value_in;
                r_mode       <= cht_pkg::t_mode'(i_req.mode);
                r_res_status <= cht_pkg::ST_NOT_FOUND;
                r_res_value  <= '0;
                r_n          <= '0;
            end
            cht_pkg::S_MUL_X:  r_h <= mul_p;
            cht_pkg::S_MUL_Y:  r_h <= r_h ^ mul_p;
            cht_pkg::S_MUL_Z:  r_h <= r_h ^ mul_p;
            cht_pkg::S_MIX_LO: begin
                r_t    <= mul_p;
                r_g_hi <= mix_g[63:32];
            end
            cht_pkg::S_MIX_HI: begin
                r_h   <= mix_v ^ (mix_v >> 13);
                r_idx <= IDXW'(mix_v ^ (mix_v >> 13));
                r_rem <= '0;
                r_bit <= 2'd3;
            end
            cht_pkg::S_MOD: begin
                r_q  <= mul_p[63:32];
                r_tq <= rem_t;
            end
            cht_pkg::S_MODQ: begin
                r_rem <= rem_n;
                r_bit <= r_bit - 1'b1;
                r_idx <= rem_n[IDXW-1:0];
            end
            cht_pkg::S_CHECK: begin
                if (c_st == cht_pkg::SL_TOMB && !r_have_tomb) begin
                    r_tomb <= r_idx;
                end
                r_n          <= r_n + 1'b1;
                r_idx        <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                r_res_status <= c_status;
                r_res_value  <= c_value;
            end
            cht_pkg::S_DONE: begin
                if (out_free) begin
                    r_out_status <= r_res_status;
                    r_out_value  <= r_res_value;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/cht_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cht_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_out_status,
    input wire logic [31:0] i_out_value
);
    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status)
            && $stable(i_out_value))
        else $error("result word changed under stall");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_status <= cht_pkg::ST_FULL)
        else $error("bad status code");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != cht_pkg::ST_FOUND |-> i_out_value == '0)
        else $error("value on a non-hit result");

    // slot clearing keeps the input closed straight after reset
    a_clear: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !i_in_ready)
        else $error("input ready during slot clearing");
endmodule

bind coord_hash_table_unit cht_chk u_cht_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_status (o_rsp.status),
    .i_out_value  (o_rsp.value_out)
);
`default_nettype wire

// ===== sim/coord_hash_table_unit_tb.sv =====
`timescale 1ns / 1ps
module coord_hash_table_unit_tb;
    import cht_pkg::*;

    localparam int N_SLOTS  = SLOTS_DEF;
    localparam int IDLE_MAX = 40000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    cht_in_if  req_if ();
    cht_out_if rsp_if ();

    coord_hash_table_unit #(.SLOTS(N_SLOTS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    typedef struct packed {
        t_status     status;
        logic [31:0] value;
    } t_answer;

    // table mirror
    t_slot_st    tbl_st   [N_SLOTS];
    logic [31:0] tbl_x    [N_SLOTS];
    logic [31:0] tbl_y    [N_SLOTS];
    logic [31:0] tbl_z    [N_SLOTS];
    logic [63:0] tbl_hash [N_SLOTS];
    logic [31:0] tbl_val  [N_SLOTS];
    int unsigned n_entries;
    logic [CNT_W-1:0] fill_limit;

    t_answer answer_q[$];
    int      n_errors;
    int      idle_cycles;
    bit      sink_stall_on;

    // recent keys for reuse
    logic [31:0] pool_x[$];
    logic [31:0] pool_y[$];
    logic [31:0] pool_z[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] coord_hash(logic [31:0] x, y, z);
        logic [63:0] h;
        h = ({32'd0, x} * 64'(HC_X)) ^ ({32'd0, y} * 64'(HC_Y)) ^ ({32'd0, z} * 64'(HC_Z));
        h = h ^ (h >> 16);
        h = h * 64'(HC_MIX);
        h = h ^ (h >> 13);
        return h;
    endfunction

    function automatic t_answer table_apply(t_mode m, logic [31:0] x, y, z, v);
        t_answer a;
        logic [63:0] h;
        int i, tomb, tgt;
        bit have_tomb, have_empty, hit;
        a.status = ST_NOT_FOUND;
        a.value  = '0;
        h = coord_hash(x, y, z);
        i = int'(h % N_SLOTS);
        have_tomb = 0; have_empty = 0; hit = 0; tomb = 0; tgt = 0;
        if (m == MODE_NOP || ((m == MODE_LOOKUP || m == MODE_REMOVE) && n_entries == 0))
            return a;
        for (int n = 0; n < N_SLOTS; n++) begin
            if (tbl_st[i] == SL_EMPTY) begin
                have_empty = 1;
                tgt = i;
                break;
            end
            if (tbl_st[i] == SL_TOMB) begin
                if (!have_tomb) begin
                    have_tomb = 1;
                    tomb = i;
                end
            end else if (tbl_hash[i] == h && tbl_x[i] == x && tbl_y[i] == y
                         && tbl_z[i] == z) begin
                hit = 1;
                tgt = i;
                break;
            end
            i = (i + 1) % N_SLOTS;
        end
        case (m)
            MODE_LOOKUP: if (hit) begin
                a.status = ST_FOUND;
                a.value  = tbl_val[tgt];
            end
            MODE_REMOVE: if (hit) begin
                tbl_st[tgt] = SL_TOMB;
                n_entries--;
                a.status = ST_REMOVED;
            end
            default: begin
                if (hit) begin
                    tbl_val[tgt] = v;
                    a.status = ST_FOUND;
                end else if (n_entries >= fill_limit || (!have_tomb && !have_empty)) begin
                    a.status = ST_FULL;
                end else begin
                    if (have_tomb) tgt = tomb;
                    tbl_x[tgt] = x; tbl_y[tgt] = y; tbl_z[tgt] = z;
                    tbl_hash[tgt] = h; tbl_val[tgt] = v;
                    tbl_st[tgt] = SL_USED;
                    n_entries++;
                    a.status = ST_INSERTED;
                end
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid stays up between back-to-back words; it drops for a gap
    task automatic send_word(t_mode m, logic [31:0] x, y, z, v);
        int g;
        g = gap_len();
        if (g != 0) begin
            req_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= m;
        req_if.key_x    <= x;
        req_if.key_y    <= y;
        req_if.key_z    <= z;
        req_if.value_in <= v;
        do @(posedge i_clk); while (!req_if.ready);
        answer_q.push_back(table_apply(m, x, y, z, v));
        if (m == MODE_INSERT) begin
            pool_x.push_back(x); pool_y.push_back(y); pool_z.push_back(z);
            if (pool_x.size() > 300) begin
                void'(pool_x.pop_front()); void'(pool_y.pop_front());
                void'(pool_z.pop_front());
            end
        end
    endtask

    // sink side: checks each result word, random stalls while sink_stall_on is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected word", 32'(rsp_if.status), 32'd0);
                end else begin
                    t_answer a;
                    a = answer_q.pop_front();
                    if (rsp_if.status !== a.status)
                        report_mismatch("status", 32'(rsp_if.status), 32'(a.status));
                    if (rsp_if.value_out !== a.value)
                        report_mismatch("value_out", rsp_if.value_out, a.value);
                end
            end
            if (!sink_stall_on) rsp_if.ready <= 1'b1;
            else rsp_if.ready <= ($urandom_range(0, 99) < 60) || ($urandom_range(0, 9) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX) begin
            $display("coord_hash_table_unit_tb: FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_fill_limit(logic [CNT_W-1:0] v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fill_limit = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15) - 8;
            1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_word(MODE_LOOKUP, 0, 0, 0, 0);
        send_word(MODE_REMOVE, 1, 2, 3, 0);
        send_word(MODE_NOP, 32'hffff_ffff, 0, 0, 32'hffff_ffff);
        send_word(MODE_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        send_word(MODE_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_word(MODE_INSERT, 0, 0, 0, 32'h1234_5678);
        send_word(MODE_INSERT, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h5a5a_a5a5);
        send_word(MODE_LOOKUP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_word(MODE_LOOKUP, 0, 0, 0, 0);
        send_word(MODE_INSERT, 0, 0, 0, 32'hdead_beef);
        send_word(MODE_LOOKUP, 0, 0, 0, 0);
        send_word(MODE_LOOKUP, 0, 0, 1, 0);
        send_word(MODE_REMOVE, 0, 0, 0, 0);
        send_word(MODE_REMOVE, 0, 0, 0, 0);
        send_word(MODE_LOOKUP, 0, 0, 0, 0);
        send_word(MODE_INSERT, 0, 0, 0, 32'h1);
        send_word(MODE_NOP, 0, 0, 0, 0);
        send_word(MODE_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
    endtask

    // random traffic, mostly on a working set of known keys
    task automatic test_random(int n_words, int key_span);
        t_mode m;
        logic [31:0] x, y, z;
        int k, r;
        for (int n = 0; n < n_words; n++) begin
            r = $urandom_range(0, 99);
            m = (r < 45) ? MODE_INSERT : (r < 72) ? MODE_LOOKUP : (r < 97) ? MODE_REMOVE : MODE_NOP;
            if (pool_x.size() != 0 && $urandom_range(0, 99) < 60) begin
                k = $urandom_range(0, pool_x.size() - 1);
                x = pool_x[k]; y = pool_y[k]; z = pool_z[k];
            end else if (key_span != 0) begin
                x = $urandom_range(0, key_span); y = $urandom_range(0, key_span);
                z = $urandom_range(0, key_span);
            end else begin
                x = rand_coord(); y = rand_coord(); z = rand_coord();
            end
            send_word(m, x, y, z, $urandom);
        end
    endtask

    // fill close to the limit to hit the full refusal
    task automatic test_fill_limit(logic [CNT_W-1:0] lim, int n_words);
        write_fill_limit(lim);
        for (int n = 0; n < n_words; n++)
            send_word(($urandom_range(0, 9) < 8) ? MODE_INSERT : MODE_REMOVE,
                      $urandom_range(0, 12), $urandom_range(0, 12), 0, $urandom);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.mode = MODE_LOOKUP;
        req_if.key_x = '0;
        req_if.key_y = '0;
        req_if.key_z = '0;
        req_if.value_in = '0;
        n_errors = 0;
        sink_stall_on = 1'b0;
        n_entries = 0;
        fill_limit = MAX_FILL_RST;
        foreach (tbl_st[i]) tbl_st[i] = SL_EMPTY;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        sink_stall_on = 1'b1;
        test_random(500, 0);
        sink_stall_on = 1'b0;
        test_fill_limit(11'd1, 40);
        test_fill_limit(11'd0, 20);
        sink_stall_on = 1'b1;
        test_fill_limit(11'd50, 150);
        test_fill_limit(11'd2047, 60);
        write_fill_limit(11'd1024);
        test_random(550, 0);
        write_fill_limit(MAX_FILL_RST);
        test_random(350, 20);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && answer_q.size() == 0)
            $display("coord_hash_table_unit_tb: PASS");
        else
            $display("coord_hash_table_unit_tb: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
design/cht_pkg.sv
design/cht_if.sv
design/cht_ram.sv
design/coord_hash_table_unit.sv
design/cht_chk.sv
sim/coord_hash_table_unit_tb.sv
